// ----- sv/spq_pkg.sv -----
// spq_pkg: constants, entry type and status codes of the stable priority queue
// used by stable_priority_queue_core; no dependencies
package spq_pkg;
  localparam int CAPACITY = 16;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef struct packed {
    logic [15:0] prio;
    logic [31:0] data;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
endpackage

// ----- sv/spq_ram.sv -----
// spq_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module spq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- sv/stable_priority_queue_core.sv -----
// stable_priority_queue_core: bounded priority queue held sorted in a ring buffer ram
// depends on spq_pkg and spq_ram
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one word per
// operation: kind_i 0 inserts data_in_i with priority prio_in_i, kind_i 1
// removes the front entry. Larger priority leaves first, equal priorities
// leave in arrival order. Each operation yields one word on the output
// channel (out_valid_o / out_stall_i): data_out_o, status_o, count_out_o.
// Entries sit in one ram as a ring, front at the head pointer.
// Steps: a remove reads the front entry from the ram, then forms the result. An
// insert walks back from the tail, moving each entry of lower priority one
// slot toward the tail by a read, then a write-back, and writes the new entry
// into the slot after the first held entry that it does not move (or at the
// front when every held entry moves). Errors (remove on empty, insert on full)
// go straight to the result. One operation is in work at a time; in_stall_o
// is high while it is.
// Reset clears the count and head pointer; the ram is not cleared.
// While the receiver stalls, the result word holds; a finished operation
// waits for the output register to empty before the next word is taken.
module stable_priority_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [31:0] data_in_i,
  input  logic [15:0] prio_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] data_out_o,
  output logic [1:0]  status_o,
  output logic [4:0]  count_out_o
);
  import spq_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_WRNEW, S_RM, S_DONE} state_e;

  state_e           state_q;
  logic [IDX_W-1:0] head_q;
  logic [CNT_W-1:0] count_q, k_q;
  entry_t           new_q;
  logic [31:0]      res_data_q;
  logic [1:0]       res_status_q;
  logic             out_valid_q;
  logic [31:0]      out_data_q;
  logic [1:0]       out_status_q;
  logic [4:0]       out_count_q;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                            input logic [CNT_W-1:0] l);
    logic [CNT_W+IDX_W:0] s;
    s = {{(CNT_W+1){1'b0}}, h} + {{(IDX_W+1){1'b0}}, l};
    if (s >= (CNT_W+IDX_W+1)'(CAPACITY)) begin
      s = s - (CNT_W+IDX_W+1)'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [4:0] cnt5(input logic [CNT_W-1:0] c);
    logic [CNT_W+4:0] w;
    w = {5'd0, c};
    return w[4:0];
  endfunction

  logic in_acc, out_free;
  assign in_acc   = (state_q == S_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign ram_rdata = entry_t'(ram_rbits);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = phys(head_q, k_q);
    ram_wdata = new_q;
    ram_raddr = head_q;
    case (state_q)
      S_IDLE: begin
        if (kind_i == KIND_INSERT) begin
          ram_raddr = phys(head_q, count_q - CNT_W'(1));
        end
      end
      S_RD: ram_raddr = phys(head_q, k_q - CNT_W'(1));
      S_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata.prio < new_q.prio) begin
          ram_wdata = ram_rdata;
        end
      end
      S_WRNEW: ram_we = 1'b1;
      default: ;
    endcase
  end

  spq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY), .AW(IDX_W)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rbits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
      new_q        <= '0;
      res_data_q   <= '0;
      res_status_q <= ST_OK;
      out_data_q   <= '0;
      out_status_q <= ST_OK;
      out_count_q  <= '0;
    end else begin
      // a finishing operation reloads the output register itself
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            new_q.data   <= data_in_i;
            new_q.prio   <= prio_in_i;
            res_data_q   <= '0;
            res_status_q <= ST_OK;
            k_q          <= count_q;
            if (kind_i == KIND_REMOVE) begin
              if (count_q == '0) begin
                res_status_q <= ST_EMPTY;
                state_q      <= S_DONE;
              end else begin
                state_q <= S_RM;
              end
            end else if (count_q == CNT_W'(CAPACITY)) begin
              res_status_q <= ST_FULL;
              state_q      <= S_DONE;
            end else if (count_q == '0) begin
              state_q <= S_WRNEW;
            end else begin
              // read of the tail entry already issued this cycle
              state_q <= S_CMP;
            end
          end
        end
        S_RD: state_q <= S_CMP;
        S_CMP: begin
          if (ram_rdata.prio >= new_q.prio) begin
            count_q <= count_q + CNT_W'(1);
            state_q <= S_DONE;
          end else begin
            // entry moved one slot toward the tail
            k_q <= k_q - CNT_W'(1);
            state_q <= (k_q == CNT_W'(1)) ? S_WRNEW : S_RD;
          end
        end
        S_WRNEW: begin
          count_q <= count_q + CNT_W'(1);
          state_q <= S_DONE;
        end
        S_RM: begin
          res_data_q <= ram_rdata.data;
          head_q     <= phys(head_q, CNT_W'(1));
          count_q    <= count_q - CNT_W'(1);
          state_q    <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_data_q   <= res_data_q;
            out_status_q <= res_status_q;
            out_count_q  <= cnt5(count_q);
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;
  assign status_o    = out_status_q;
  assign count_out_o = out_count_q;
endmodule
